// ===== design/bbc_pkg.sv =====
// Shared types and codes for the block buffer cache tag store.
package bbc_pkg;

  // Request kinds.
  typedef enum logic {
    OP_GET     = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // Reply codes.
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_BUSY     = 3'd2,
    ST_NOFREE   = 3'd3,
    ST_RELEASED = 3'd4,
    ST_REL_ERR  = 3'd5
  } status_t;

  // One request beat.
  typedef struct packed {
    op_t         operation;
    logic [15:0] disk_block;
    logic [5:0]  buffer_index;
  } in_item_t;

  // One reply beat.
  typedef struct packed {
    status_t     status;
    logic [5:0]  granted_buffer;
    logic [15:0] evicted_block;
  } out_item_t;

  // Update broadcast from the controller to the row of buffer cells.
  typedef struct packed {
    logic grab;   // the selected cell goes busy and leaves the free list
    logic retag;  // with grab: the selected cell takes the new tag
    logic drop;   // the selected cell goes free at the free-list tail
  } cell_cmd_t;

endpackage

// ===== design/bbc_cell.sv =====
// One buffer slot: tag, busy flag and its position in the LRU free list.
module bbc_cell #(
  parameter int IDX_W = 6,
  parameter int TAG_W = 16,
  parameter logic [TAG_W-1:0] RST_TAG = '0,
  parameter logic [IDX_W-1:0] RST_RANK = '0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TAG_W-1:0]     lookup_tag,
  input  bbc_pkg::cell_cmd_t   cmd,
  input  logic                 sel,
  input  logic [IDX_W-1:0]     cmd_rank,
  input  logic [TAG_W-1:0]     new_tag,
  output logic                 match,
  output logic                 busy,
  output logic                 head,
  output logic [TAG_W-1:0]     tag,
  output logic [IDX_W-1:0]     rank
);

  logic [TAG_W-1:0] tag_r;
  logic             busy_r;
  logic [IDX_W-1:0] rank_r;

  // Local lookup results. A free cell of rank zero is the free-list head.
  assign match = (tag_r == lookup_tag);
  assign busy  = busy_r;
  assign head  = !busy_r && (rank_r == '0);
  assign tag   = tag_r;
  assign rank  = rank_r;

  // A grab removes one free slot at rank cmd_rank, so every free cell behind
  // it moves up by one. A drop puts the selected cell at the tail.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= RST_TAG;
      busy_r <= 1'b0;
      rank_r <= RST_RANK;
    end else begin
      if (cmd.grab) begin
        if (sel) begin
          busy_r <= 1'b1;
          if (cmd.retag) begin
            tag_r <= new_tag;
          end
        end else if (!busy_r && (rank_r > cmd_rank)) begin
          rank_r <= rank_r - 1'b1;
        end
      end
      if (cmd.drop && sel) begin
        busy_r <= 1'b0;
        rank_r <= cmd_rank;
      end
    end
  end

endmodule

// ===== design/block_buffer_cache_lru_top.sv =====
// Top level of the block buffer cache tag store: request sequencer and cell row.
//
//   channel | ports                          | beat
//   --------+--------------------------------+----------------------------------
//   request | in_valid, in_ready, in_data    | operation, block number, index
//   reply   | out_valid, out_ready, out_data | status, granted buffer, evicted
//
// Every request passes through acceptance, tag compare in all cells, lowest-match
// selection, and commit of the cell update together with the reply register.
// A new request is accepted once the sequencer is back in idle, even while the
// previous reply still waits to be taken; commit holds while the reply register
// is full and not being taken. Reset (rst_n low at a clock edge) restores all tags,
// busy flags and free-list ranks.
module block_buffer_cache_lru_top #(
  parameter int NUM_BUFFERS = 64,
  parameter int BLOCK_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bbc_pkg::out_item_t out_data
);

  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam int TAG_W = BLOCK_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SELECT,
    S_COMMIT
  } state_t;

  state_t              state_r;
  bbc_pkg::in_item_t   req_r;
  bbc_pkg::out_item_t  res_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    free_count_r;
  logic [NUM_BUFFERS-1:0] match_vec_r;
  logic [NUM_BUFFERS-1:0] head_vec_r;
  logic [NUM_BUFFERS-1:0] hit_oh_r;
  logic                found_r;

  // Cell row outputs.
  logic [NUM_BUFFERS-1:0] match_vec;
  logic [NUM_BUFFERS-1:0] busy_vec;
  logic [NUM_BUFFERS-1:0] head_vec;
  logic [TAG_W-1:0]       tag_arr  [NUM_BUFFERS];
  logic [IDX_W-1:0]       rank_arr [NUM_BUFFERS];

  // Commit-cycle decision.
  logic [TAG_W-1:0]       lookup_tag;
  logic [NUM_BUFFERS-1:0] rel_oh;
  logic [NUM_BUFFERS-1:0] sel_vec;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       head_idx;
  logic [IDX_W-1:0]       hit_rank;
  logic [TAG_W-1:0]       head_tag;
  logic                   hit_busy;
  logic                   rel_busy;
  logic                   commit_go;
  bbc_pkg::cell_cmd_t     cmd_c;
  bbc_pkg::cell_cmd_t     cell_cmd;
  logic [IDX_W-1:0]       cmd_rank;
  bbc_pkg::out_item_t     res_nxt;
  logic [CNT_W-1:0]       free_count_nxt;

  // One-hot to index.
  function automatic logic [IDX_W-1:0] enc(input logic [NUM_BUFFERS-1:0] oh);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (oh[i]) begin
        r = r | IDX_W'(i);
      end
    end
    return r;
  endfunction

  assign lookup_tag = TAG_W'(req_r.disk_block);
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = res_r;
  assign commit_go  = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign cell_cmd   = commit_go ? cmd_c : '0;

  // Row of buffer cells; cell i starts as buffer i at free-list rank i.
  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    bbc_cell #(
      .IDX_W    (IDX_W),
      .TAG_W    (TAG_W),
      .RST_TAG  (TAG_W'(g + 1)),
      .RST_RANK (IDX_W'(g))
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .lookup_tag (lookup_tag),
      .cmd        (cell_cmd),
      .sel        (sel_vec[g]),
      .cmd_rank   (cmd_rank),
      .new_tag    (lookup_tag),
      .match      (match_vec[g]),
      .busy       (busy_vec[g]),
      .head       (head_vec[g]),
      .tag        (tag_arr[g]),
      .rank       (rank_arr[g])
    );
  end

  // Gather the selected cells' fields and decide the outcome of the request.
  always_comb begin
    hit_idx  = enc(hit_oh_r);
    head_idx = enc(head_vec_r);
    hit_rank = '0;
    head_tag = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      rel_oh[i] = (32'(req_r.buffer_index) == i);
      if (hit_oh_r[i]) begin
        hit_rank = hit_rank | rank_arr[i];
      end
      if (head_vec_r[i]) begin
        head_tag = head_tag | tag_arr[i];
      end
    end
    hit_busy = |(hit_oh_r & busy_vec);
    rel_busy = |(rel_oh & busy_vec);

    cmd_c                  = '0;
    sel_vec                = '0;
    cmd_rank               = '0;
    free_count_nxt         = free_count_r;
    res_nxt.status         = bbc_pkg::ST_REL_ERR;
    res_nxt.granted_buffer = req_r.buffer_index;
    res_nxt.evicted_block  = '0;

    case (req_r.operation)
      bbc_pkg::OP_GET: begin
        if (found_r) begin
          res_nxt.granted_buffer = 6'(hit_idx);
          if (hit_busy) begin
            res_nxt.status = bbc_pkg::ST_BUSY;
          end else begin
            res_nxt.status = bbc_pkg::ST_HIT;
            cmd_c.grab     = 1'b1;
            sel_vec        = hit_oh_r;
            cmd_rank       = hit_rank;
            free_count_nxt = free_count_r - 1'b1;
          end
        end else if (free_count_r == '0) begin
          res_nxt.status         = bbc_pkg::ST_NOFREE;
          res_nxt.granted_buffer = '0;
        end else begin
          res_nxt.status         = bbc_pkg::ST_MISS;
          res_nxt.granted_buffer = 6'(head_idx);
          res_nxt.evicted_block  = 16'(head_tag);
          cmd_c.grab             = 1'b1;
          cmd_c.retag            = 1'b1;
          sel_vec                = head_vec_r;
          free_count_nxt         = free_count_r - 1'b1;
        end
      end
      bbc_pkg::OP_RELEASE: begin
        if (rel_busy) begin
          res_nxt.status = bbc_pkg::ST_RELEASED;
          cmd_c.drop     = 1'b1;
          sel_vec        = rel_oh;
          cmd_rank       = IDX_W'(free_count_r);
          free_count_nxt = free_count_r + 1'b1;
        end
      end
      default: begin
        res_nxt.status = bbc_pkg::ST_REL_ERR;
      end
    endcase
  end

  // Sequencer, request and reply registers, free count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_count_r <= CNT_W'(NUM_BUFFERS);
      found_r      <= 1'b0;
    end else begin
      // A taken reply empties the register unless a new one lands in the same cycle.
      if (out_valid_r && out_ready && !commit_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          match_vec_r <= match_vec;
          head_vec_r  <= head_vec;
          state_r     <= S_SELECT;
        end
        S_SELECT: begin
          // Lowest-numbered matching buffer wins.
          hit_oh_r <= match_vec_r & (~match_vec_r + 1'b1);
          found_r  <= |match_vec_r;
          state_r  <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) begin
            res_r        <= res_nxt;
            out_valid_r  <= 1'b1;
            free_count_r <= free_count_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The free count tracks the number of cells that are not busy.
  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(~busy_vec) == free_count_r)
    else $error("free count out of step with cell busy flags");

  // A nonempty free list has exactly one head, an empty one none.
  a_one_head: assert property (@(posedge clk) disable iff (!rst_n)
    (free_count_r != '0) ? $onehot(head_vec) : (head_vec == '0))
    else $error("free-list head is not unique");

  // A reply appears only out of a commit.
  a_reply_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("reply raised outside commit");

  // Cells only change on a committed request.
  a_cmd_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_cmd != '0) |-> (state_r == S_COMMIT) && $onehot0(sel_vec))
    else $error("cell update outside commit or to several cells");

endmodule

// ===== verif/tb_block_buffer_cache_lru_top.sv =====
// Self-checking testbench for the block buffer cache tag store with its LRU free list.
`timescale 1ns / 1ps

module tb_block_buffer_cache_lru_top;

  localparam int NBUF = 64;
  localparam int BLOCK_POOL = 96;
  localparam int RANDOM_REQUESTS = 700;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bbc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  bbc_pkg::out_item_t out_data;

  block_buffer_cache_lru_top #(
    .NUM_BUFFERS(NBUF),
    .BLOCK_BITS (16)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the tag store and its free list.
  logic [15:0] tag_of [NBUF];
  logic        held [NBUF];
  logic [5:0]  lru_next [NBUF];
  logic [5:0]  lru_prev [NBUF];
  logic        on_lru [NBUF];
  logic [5:0]  lru_head;
  logic [5:0]  lru_tail;
  logic [6:0]  lru_count;

  bbc_pkg::in_item_t  pending_requests [$];
  bbc_pkg::out_item_t expected_replies [$];

  int   total_requests;
  int   accepted_beats = 0;
  int   replies_seen = 0;
  int   requests_sent = 0;
  int   fail_count = 0;
  int   idle_left;
  int   hold_left;
  bit   held_off;
  logic in_fire;

  // Takes a buffer out of the free list, if it is on it.
  function automatic void lru_unlink(logic [5:0] x);
    logic [5:0] p;
    logic [5:0] n;
    if (!on_lru[x] || lru_count == 0) return;
    if (lru_count == 1) begin
      lru_count = 0;
    end else begin
      p = lru_prev[x];
      n = lru_next[x];
      lru_next[p] = n;
      lru_prev[n] = p;
      if (lru_head == x) lru_head = n;
      if (lru_tail == x) lru_tail = p;
      lru_count = lru_count - 1;
    end
    on_lru[x] = 1'b0;
  endfunction

  // Applies one request to the shadow state and returns the reply it must produce.
  function automatic bbc_pkg::out_item_t serve_request(bbc_pkg::in_item_t req);
    bbc_pkg::out_item_t rep;
    int                 hit_idx;
    logic [5:0]         v;
    logic [5:0]         x;
    rep = '0;
    if (req.operation == bbc_pkg::OP_GET) begin
      // The lowest-numbered buffer holding the tag wins.
      hit_idx = -1;
      for (int i = NBUF - 1; i >= 0; i--) begin
        if (tag_of[i] == req.disk_block) hit_idx = i;
      end
      if (hit_idx >= 0) begin
        rep.granted_buffer = hit_idx[5:0];
        if (held[hit_idx]) begin
          rep.status = bbc_pkg::ST_BUSY;
        end else begin
          held[hit_idx] = 1'b1;
          lru_unlink(hit_idx[5:0]);
          rep.status = bbc_pkg::ST_HIT;
        end
      end else if (lru_count == 0) begin
        rep.status = bbc_pkg::ST_NOFREE;
      end else begin
        // A miss reuses the least recently released buffer.
        v = lru_head;
        lru_unlink(v);
        rep.evicted_block  = tag_of[v];
        tag_of[v]          = req.disk_block;
        held[v]            = 1'b1;
        rep.granted_buffer = v;
        rep.status         = bbc_pkg::ST_MISS;
      end
    end else begin
      x = req.buffer_index;
      rep.granted_buffer = x;
      if (!held[x]) begin
        rep.status = bbc_pkg::ST_REL_ERR;
      end else begin
        held[x] = 1'b0;
        // Append at the tail of the free list.
        if (!on_lru[x]) begin
          if (lru_count == 0) begin
            lru_head    = x;
            lru_tail    = x;
            lru_next[x] = x;
            lru_prev[x] = x;
          end else begin
            lru_next[lru_tail] = x;
            lru_prev[x]        = lru_tail;
            lru_next[x]        = lru_head;
            lru_prev[lru_head] = x;
            lru_tail           = x;
          end
          lru_count = lru_count + 1;
          on_lru[x] = 1'b1;
        end
        rep.status = bbc_pkg::ST_RELEASED;
      end
    end
    return rep;
  endfunction

  // Gap length between beats: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic queue_request(bbc_pkg::op_t op, logic [15:0] blk, logic [5:0] idx);
    bbc_pkg::in_item_t item;
    item.operation    = op;
    item.disk_block   = blk;
    item.buffer_index = idx;
    pending_requests.push_back(item);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sender: one beat at a time from the pending queue, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      idle_left = 0;
    end else if (!in_valid || in_fire) begin
      if (in_valid) begin
        requests_sent++;
        // Every third stretch of a hundred beats runs back to back.
        idle_left = ((requests_sent / 100) % 3 == 1) ? 0 : pick_gap();
      end
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      held_off  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (replies_seen >= 250 && !held_off) begin
      held_off  = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else if ((replies_seen / 100) % 3 == 2 || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      hold_left = pick_gap();
      out_ready <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted request and checks each taken reply.
  always @(posedge clk) begin
    bbc_pkg::out_item_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_replies.push_back(serve_request(in_data));
        accepted_beats++;
      end
      if (out_valid && out_ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: reply beat with none expected, actual status %0d buffer %0d",
                   $time, out_data.status, out_data.granted_buffer);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("granted_buffer", want.granted_buffer, out_data.granted_buffer);
          check_field("evicted_block", want.evicted_block, out_data.evicted_block);
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int           n;
    int           phase_len;
    int           get_pct;
    logic [15:0]  blk;
    bbc_pkg::op_t op;

    rst_n = 1'b0;

    // Shadow state after reset: tags i+1, all free, list in index order.
    for (int i = 0; i < NBUF; i++) begin
      tag_of[i]   = 16'(i + 1);
      held[i]     = 1'b0;
      lru_next[i] = 6'(i + 1);
      lru_prev[i] = 6'(i + NBUF - 1);
      on_lru[i]   = 1'b1;
    end
    lru_head  = '0;
    lru_tail  = 6'(NBUF - 1);
    lru_count = 7'(NBUF);

    // Directed requests: hits, busy retry, misses, release errors, mid-list unlink.
    queue_request(bbc_pkg::OP_GET, 16'd1, 6'd63);
    queue_request(bbc_pkg::OP_GET, 16'd1, 6'd0);
    queue_request(bbc_pkg::OP_GET, 16'd0, 6'd0);
    queue_request(bbc_pkg::OP_GET, 16'd2, 6'd0);
    queue_request(bbc_pkg::OP_GET, 16'hFFFF, 6'd63);
    queue_request(bbc_pkg::OP_GET, 16'd64, 6'd0);
    queue_request(bbc_pkg::OP_RELEASE, 16'hFFFF, 6'd0);
    queue_request(bbc_pkg::OP_RELEASE, 16'd0, 6'd0);
    queue_request(bbc_pkg::OP_RELEASE, 16'd0, 6'd62);
    queue_request(bbc_pkg::OP_RELEASE, 16'd0, 6'd63);
    queue_request(bbc_pkg::OP_GET, 16'd64, 6'd0);
    queue_request(bbc_pkg::OP_GET, 16'hAAAA, 6'h2A);
    queue_request(bbc_pkg::OP_GET, 16'h5555, 6'h15);
    queue_request(bbc_pkg::OP_RELEASE, 16'h5555, 6'd1);
    queue_request(bbc_pkg::OP_RELEASE, 16'hAAAA, 6'd2);
    queue_request(bbc_pkg::OP_GET, 16'd0, 6'd0);
    queue_request(bbc_pkg::OP_RELEASE, 16'd0, 6'd1);
    queue_request(bbc_pkg::OP_GET, 16'h8000, 6'h20);
    queue_request(bbc_pkg::OP_RELEASE, 16'd0, 6'd63);

    // Random phases alternate between filling the pool and draining it.
    n = 0;
    get_pct = 0;
    while (n < RANDOM_REQUESTS) begin
      phase_len = $urandom_range(60, 140);
      get_pct   = (get_pct == 80) ? 25 : 80;
      for (int k = 0; k < phase_len && n < RANDOM_REQUESTS; k++) begin
        op  = ($urandom_range(0, 99) < get_pct) ? bbc_pkg::OP_GET : bbc_pkg::OP_RELEASE;
        blk = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, BLOCK_POOL - 1))
                                           : 16'($urandom_range(0, 65535));
        queue_request(op, blk, 6'($urandom_range(0, NBUF - 1)));
        n++;
      end
    end
    total_requests = pending_requests.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_beats < total_requests) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
